// ----- design/cce_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cce_pkg
// Shared constants and the command type passed from front to back.
// ----------------------------------------------------------------------------
package cce_pkg;

   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   localparam int MaxBytes = 3;
   localparam int CntW     = $clog2(MaxBytes + 1);

   // one input beat's worth of output bytes; bytes[0] goes out first
   typedef struct packed {
      logic [CntW-1:0]              count;
      logic [MaxBytes-1:0][7:0]     bytes;
   } cmd_type;

endpackage

// ----- design/cce_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cce_front
// Accepts source bytes, tracks comment/string state, builds output commands.
// ----------------------------------------------------------------------------
module cce_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       in_byte,
   output logic             push,
   output cce_pkg::cmd_type cmd
);

   logic inside_comment_ff, inside_comment_in;
   logic line_comment_ff, line_comment_in;
   logic inside_string_ff, inside_string_in;
   logic slash_armed_ff, slash_armed_in;
   logic star_armed_ff, star_armed_in;

   always_comb begin
      logic                         done;
      logic [cce_pkg::CntW-1:0]     n;
      logic [cce_pkg::MaxBytes-1:0][7:0] b;
      done              = 1'b0;
      n                 = '0;
      b                 = '0;
      inside_comment_in = inside_comment_ff;
      line_comment_in   = line_comment_ff;
      inside_string_in  = inside_string_ff;
      slash_armed_in    = slash_armed_ff;
      star_armed_in     = star_armed_ff;

      if (slash_armed_ff) begin
         slash_armed_in = 1'b0;
         if (in_byte == cce_pkg::CH_STAR || in_byte == cce_pkg::CH_SLASH) begin
            if (in_byte == cce_pkg::CH_SLASH) line_comment_in = 1'b1;
            inside_comment_in = 1'b1;
            done = 1'b1;   // opener's second byte is dropped
         end
      end

      if (!done) begin
         if (star_armed_ff) begin
            star_armed_in = 1'b0;
            if (in_byte == cce_pkg::CH_SLASH) begin
               inside_comment_in = 1'b0;
               b[0] = cce_pkg::CH_NEWLINE;
               b[1] = cce_pkg::CH_NEWLINE;
               n    = 2'd2;
            end else begin
               b[0] = cce_pkg::CH_STAR;
               n    = 2'd1;
            end
         end

         if (in_byte == cce_pkg::CH_SLASH && !inside_comment_in && !inside_string_in)
            slash_armed_in = 1'b1;
         if (in_byte == cce_pkg::CH_STAR && inside_comment_in && !inside_string_in)
            star_armed_in = 1'b1;
         if (in_byte == cce_pkg::CH_QUOTE && !inside_comment_in)
            inside_string_in = !inside_string_in;

         if (inside_comment_in && !star_armed_in) begin
            b[n[1:0]] = in_byte;
            n = n + 2'd1;
            if (line_comment_in && in_byte == cce_pkg::CH_NEWLINE) begin
               b[n[1:0]] = cce_pkg::CH_NEWLINE;
               n = n + 2'd1;
               inside_comment_in = 1'b0;
               line_comment_in   = 1'b0;
            end
         end
      end

      cmd.count = n;
      cmd.bytes = b;
      push      = accept && (n != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_comment_ff <= 1'b0;
         line_comment_ff   <= 1'b0;
         inside_string_ff  <= 1'b0;
         slash_armed_ff    <= 1'b0;
         star_armed_ff     <= 1'b0;
      end else if (accept) begin
         inside_comment_ff <= inside_comment_in;
         line_comment_ff   <= line_comment_in;
         inside_string_ff  <= inside_string_in;
         slash_armed_ff    <= slash_armed_in;
         star_armed_ff     <= star_armed_in;
      end
   end

endmodule

// ----- design/cce_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cce_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module cce_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cce_pkg::cmd_type push_cmd,
   output logic             not_full,
   input  logic             pop,
   output logic             not_empty,
   output cce_pkg::cmd_type head_cmd
);

   cce_pkg::cmd_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   assign not_full  = (fill_ff != 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign head_cmd  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ----- design/cce_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cce_back
// Plays out each queued command one byte per beat into the output register.
// ----------------------------------------------------------------------------
module cce_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  cce_pkg::cmd_type head_cmd,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast
);

   logic [cce_pkg::CntW-1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic       load;

   always_comb begin
      load     = head_valid && (!valid_ff || rsp_tready);
      last_in  = (idx_ff == head_cmd.count - 2'd1);
      data_in  = head_cmd.bytes[idx_ff];
      pop      = load && last_in;
      idx_in   = idx_ff;
      if (load) idx_in = last_in ? '0 : idx_ff + 2'd1;
      valid_in = valid_ff;
      if (load) valid_in = 1'b1;
      else if (rsp_tready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ----- design/c_style_comment_extractor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_style_comment_extractor
// Streams source text in and passes on only the text of block/line comments.
// ----------------------------------------------------------------------------
// Usage:
//   req_* : one source byte per beat (req_tdata[7:0] = in_byte).
//   rsp_* : extracted comment bytes, one per beat; rsp_tlast marks the last
//           byte produced by a given input byte. Input bytes that produce
//           nothing (code outside comments, opener bytes, a held star)
//           give no output beat.
//   Each input byte yields 0 to 3 output bytes (held star, the byte itself,
//   doubled newline or star-slash newline pair).
//   Commands are registered in the queue, bytes in the output register.
//   Throughput: one input beat per cycle while output keeps up; the back end
//   emits one byte per ready cycle, so input rate is set by output byte count.
//   A 2-entry command queue separates the front classifier from the byte
//   player; the front stalls (req_tready low) only when it is full.
//   Receiver stall: the output register holds its beat; the queue fills and
//   then backpressures the input.
//   Reset: synchronous, clears all comment/string flags, queue and output.
// ----------------------------------------------------------------------------
module c_style_comment_extractor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast    // run_end
);

   logic             accept;
   logic             push;
   cce_pkg::cmd_type push_cmd;
   logic             not_full;
   logic             pop;
   logic             not_empty;
   cce_pkg::cmd_type head_cmd;

   assign req_tready = not_full;
   assign accept     = req_tvalid && not_full;

   cce_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_tdata),
      .push    (push),
      .cmd     (push_cmd)
   );

   cce_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .not_full  (not_full),
      .pop       (pop),
      .not_empty (not_empty),
      .head_cmd  (head_cmd)
   );

   cce_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (not_empty),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the C comment extractor.
// ----------------------------------------------------------------------------
// Source text goes in one byte per beat. A behavioral model of the comment
// and string flags predicts the output bytes for each accepted beat, and a
// monitor checks every output beat against the oldest prediction.
// Stimulus has three parts:
//   - a short directed sequence: both comment styles, strings, escapes, and
//     the odd parsing rules;
//   - random text made of code, strings, comments and noise;
//   - pressure phases: a long output stall while input keeps coming, and one
//     pause on the input side until the output has drained.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CycleLimit = 200000;

   // expected output beat: one byte of comment text plus its end-of-run flag
   typedef struct packed {
      logic [7:0] text;
      logic       run_end;
   } comment_beat_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] in_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] out_byte
   logic       rsp_tlast;            // run_end

   // idling control; idle_on and rx_long_hold are written by the test sequence
   logic idle_on      = 1'b0;
   logic rx_long_hold = 1'b0;
   int   rx_gap       = 0;

   // model state: same flags the block keeps
   logic in_comment = 1'b0;
   logic in_line    = 1'b0;
   logic in_string  = 1'b0;
   logic slash_seen = 1'b0;
   logic star_seen  = 1'b0;

   comment_beat_type comment_q[$];   // predicted output beats, oldest first

   int err_count   = 0;
   int bytes_sent  = 0;
   int cycle_count = 0;

   c_style_comment_extractor uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------------
   // Comment extraction model. Updates the flags for one source byte and
   // queues the bytes it produces; the last one carries run_end.
   // ------------------------------------------------------------------------
   function automatic void predict_extract(input logic [7:0] c);
      logic [7:0] outs[$];
      // armed slash: star or slash opens a comment and is itself dropped
      if (slash_seen) begin
         slash_seen = 1'b0;
         if (c == cce_pkg::CH_STAR || c == cce_pkg::CH_SLASH) begin
            if (c == cce_pkg::CH_SLASH) in_line = 1'b1;
            in_comment = 1'b1;
            return;
         end
      end
      // held star: star-slash closes (two newlines), else star comes back out
      if (star_seen) begin
         star_seen = 1'b0;
         if (c == cce_pkg::CH_SLASH) begin
            in_comment = 1'b0;
            outs.push_back(cce_pkg::CH_NEWLINE);
            outs.push_back(cce_pkg::CH_NEWLINE);
         end else begin
            outs.push_back(cce_pkg::CH_STAR);
         end
      end
      // closing slash falls through here too and re-arms an opening
      if (c == cce_pkg::CH_SLASH && !in_comment && !in_string) slash_seen = 1'b1;
      if (c == cce_pkg::CH_STAR && in_comment && !in_string) star_seen = 1'b1;
      if (c == cce_pkg::CH_QUOTE && !in_comment) in_string = !in_string;
      if (in_comment && !star_seen) begin
         outs.push_back(c);
         // line comment ends at newline, which goes out twice
         if (in_line && c == cce_pkg::CH_NEWLINE) begin
            outs.push_back(cce_pkg::CH_NEWLINE);
            in_comment = 1'b0;
            in_line    = 1'b0;
         end
      end
      foreach (outs[i])
         comment_q.push_back('{text: outs[i], run_end: (i == outs.size() - 1)});
   endfunction

   // ------------------------------------------------------------------------
   // Monitor: predict on each accepted input beat, check each output beat.
   // Both sides sampled at the same edge the handshake happens.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      comment_beat_type exp_beat;
      if (!reset) begin
         if (req_tvalid && req_tready) predict_extract(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (comment_q.size() == 0) begin
               if (err_count < 10)
                  $display("unexpected output beat: out_byte %02h run_end %0b",
                           rsp_tdata, rsp_tlast);
               err_count++;
            end else begin
               exp_beat = comment_q.pop_front();
               if (rsp_tdata !== exp_beat.text || rsp_tlast !== exp_beat.run_end) begin
                  if (err_count < 10)
                     $display("mismatch: out_byte exp %02h got %02h, run_end exp %0b got %0b",
                              exp_beat.text, rsp_tdata, exp_beat.run_end, rsp_tlast);
                  err_count++;
               end
            end
         end
      end
   end

   // Receiver: random stalls while idling is on, plus the long hold requested by
   // the backpressure test.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rx_long_hold) begin
         rsp_tready <= 1'b0;
      end else if (rx_gap > 0) begin
         rsp_tready <= 1'b0;
         rx_gap     <= rx_gap - 1;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
         rsp_tready <= 1'b0;
         rx_gap     <= int'($urandom_range(0, 3));
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Shared helpers
   // ------------------------------------------------------------------------

   // Offer one byte and hold it until accepted. With idling on, a random gap
   // may come first.
   task automatic send_byte(input logic [7:0] b);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send_byte(s[i]);
   endtask

   // wait past the current edge first so the monitor has queued the last accepted beat
   task automatic wait_drained();
      @(posedge clock);
      while (comment_q.size() != 0) @(posedge clock);
   endtask

   // body byte: leans toward the characters the parser reacts to
   function automatic logic [7:0] text_byte();
      case ($urandom_range(0, 9))
         0:       return cce_pkg::CH_STAR;
         1:       return cce_pkg::CH_SLASH;
         2:       return cce_pkg::CH_NEWLINE;
         3:       return cce_pkg::CH_QUOTE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // One well-formed piece of source text with random content; two in ten
   // are raw noise.
   task automatic send_fragment();
      int kind;
      int len;
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 8);
      case (kind)
         0, 1: begin
            repeat (len) send_byte(8'($urandom_range(32, 126)));
         end
         2: begin
            send_byte(cce_pkg::CH_QUOTE);
            repeat (len) send_byte(text_byte());
            send_byte(cce_pkg::CH_QUOTE);
         end
         3, 4, 5: begin
            send_byte(cce_pkg::CH_SLASH);
            send_byte(cce_pkg::CH_STAR);
            repeat (len) send_byte(text_byte());
            send_byte(cce_pkg::CH_STAR);
            send_byte(cce_pkg::CH_SLASH);
         end
         6, 7: begin
            send_byte(cce_pkg::CH_SLASH);
            send_byte(cce_pkg::CH_SLASH);
            repeat (len) send_byte(text_byte());
            send_byte(cce_pkg::CH_NEWLINE);
         end
         default: begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Directed walk through the parsing rules:
   //  - slash-star inside a string is plain text; backslash does not escape
   //    the closing quote, so the next slash-star opens a comment
   //  - 00 and FF inside a block comment pass through
   //  - a star not followed by slash comes back out ahead of the next byte
   //  - the closing slash re-arms, so star-slash-slash starts a line comment
   //  - line comment newline is doubled
   //  - star-slash ends a line comment but leaves the line flag set, so the
   //    next block comment ends at its first newline
   task automatic test_directed();
      send_text("\"/*\\\"");
      send_text("/*");
      send_byte(8'h00);
      send_byte(8'hFF);
      send_text("*a*/");
      send_text("/z\n");
      send_text("//q*/x/*r\n");
   endtask

   task automatic test_random_text(input int n);
      int stop_at;
      stop_at = bytes_sent + n;
      while (bytes_sent < stop_at) send_fragment();
   endtask

   // Sender stops and waits for every predicted byte, then carries on.
   task automatic test_drain_pause();
      test_random_text(30);
      req_tvalid <= 1'b0;
      wait_drained();
      test_random_text(30);
   endtask

   // Output held off for a long stretch while a comment body streams in;
   // every body byte produces output, so the block must stall its input.
   task automatic test_backpressure();
      send_text("/*");
      fork
         begin
            rx_long_hold <= 1'b1;
            repeat (60) @(posedge clock);
            rx_long_hold <= 1'b0;
         end
         repeat (30) send_byte(8'($urandom_range(48, 122)));
      join
      send_text("*/;");
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      idle_on <= 1'b1;
      test_random_text(70);
      test_drain_pause();
      test_backpressure();
      test_random_text(80);
      // last stretch at full rate
      idle_on <= 1'b0;
      test_random_text(40);

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);
      // predicted beats that never came out
      if (comment_q.size() != 0) begin
         if (err_count < 10)
            $display("missing output beats: %0d still expected", comment_q.size());
         err_count++;
      end
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/cce_pkg.sv
design/cce_front.sv
design/cce_queue.sv
design/cce_back.sv
design/c_style_comment_extractor.sv
tb/tb_top.sv
